### hdl/rms_level_detector_unit_macros.svh
// ----------------------------------------------------------------------------
// rms_level_detector_unit_macros.svh
// Assertion shorthands for the RMS level detector, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RMS_LEVEL_DETECTOR_UNIT_MACROS_SVH
`define RMS_LEVEL_DETECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define RLD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rld assertion failed");

// next-cycle implication
`define RLD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rld assertion failed");

`endif

### hdl/rld_pkg.sv
// ----------------------------------------------------------------------------
// rld_pkg
// Shared constants, types and width helpers of the RMS level detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rld_pkg;

	localparam int MAX_WINDOW_DEF = 4096;
	localparam int SENS_CENTER    = 50;
	localparam int SENS_STEP      = 300;
	localparam int SENS_RESET     = 50;
	localparam int SQ_MAX         = 65025;   // 255 * 255
	localparam int MEAN_W         = 16;
	localparam int ROOT_W         = MEAN_W / 2;
	localparam int SENS_W         = 7;
	localparam int BASE_W         = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 16;
	localparam int QUEUE_DEPTH    = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_BASE  = 1'd1;

	typedef struct packed {
		logic [SENS_W-1:0] sensitivity;
		logic [BASE_W-1:0] noise_base;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic busy;
	} bk_stat_t;

	function automatic int cnt_width(input int max_w);
		return $clog2(max_w + 1);
	endfunction

	function automatic int sum_width(input int max_w);
		longint m;
		m = longint'(max_w) * longint'(SQ_MAX);
		return $clog2(m + 64'sd1);
	endfunction

endpackage

### hdl/rld_ifs.sv
// ----------------------------------------------------------------------------
// rld_ifs
// Valid/ready channels of the RMS level detector: samples in, levels out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] sample;
	logic       last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface rld_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] rms_level;
	logic       above_threshold;

	modport source (output valid, output rms_level, output above_threshold, input ready);
	modport sink   (input valid, input rms_level, input above_threshold, output ready);
endinterface

### hdl/rld_front.sv
// ----------------------------------------------------------------------------
// rld_front
// Sample accumulator: squares each sample into a running sum, counts the
// window and hands the finished sum and count to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rld_front
	import rld_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int CNT_W = cnt_width(MAX_WINDOW),
	localparam int SUM_W = sum_width(MAX_WINDOW)
) (
	input  logic             clk,
	input  logic             arst_n,
	rld_in_if.sink           samples,
	input  q_stat_t          q_stat,
	output logic             push,
	output logic [SUM_W-1:0] push_sum,
	output logic [CNT_W-1:0] push_cnt
);

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      sq;
	logic             take;
	logic             beat;

	assign samples.ready = !q_stat.full;
	assign beat          = samples.valid && samples.ready;

	assign sq       = 16'(samples.sample) * 16'(samples.sample);
	// drop samples once the window is full
	assign take     = cnt_q < CNT_W'(MAX_WINDOW);
	assign push_sum = take ? sum_q + SUM_W'(sq) : sum_q;
	assign push_cnt = take ? cnt_q + CNT_W'(1) : cnt_q;
	assign push     = beat && samples.last_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (beat) begin
			if (samples.last_sample) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= push_sum;
				cnt_q <= push_cnt;
			end
		end
	end

endmodule

### hdl/rld_queue.sv
// ----------------------------------------------------------------------------
// rld_queue
// Short FIFO of finished windows between accumulator and arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rld_queue
	import rld_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int CNT_W = cnt_width(MAX_WINDOW),
	localparam int SUM_W = sum_width(MAX_WINDOW),
	localparam int PTR_W = $clog2(QUEUE_DEPTH),
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [SUM_W-1:0] push_sum,
	input  logic [CNT_W-1:0] push_cnt,
	input  logic             pop,
	output logic [SUM_W-1:0] pop_sum,
	output logic [CNT_W-1:0] pop_cnt,
	output q_stat_t          q_stat
);

	logic [SUM_W-1:0]  sum_mem [QUEUE_DEPTH];
	logic [CNT_W-1:0]  cnt_mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [FILL_W-1:0] fill_q;

	assign q_stat.full  = fill_q == FILL_W'(QUEUE_DEPTH);
	assign q_stat.empty = fill_q == '0;
	assign pop_sum      = sum_mem[rp_q];
	assign pop_cnt      = cnt_mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			sum_mem[wp_q] <= push_sum;
			cnt_mem[wp_q] <= push_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

### hdl/rld_back.sv
// ----------------------------------------------------------------------------
// rld_back
// Window arithmetic: radix-2 long division of sum by count, bit-pair
// square root of the mean, threshold compare and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rld_back
	import rld_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int CNT_W = cnt_width(MAX_WINDOW),
	localparam int SUM_W = sum_width(MAX_WINDOW),
	localparam int STEP_W = $clog2(MEAN_W)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  q_stat_t          q_stat,
	input  logic [SUM_W-1:0] pop_sum,
	input  logic [CNT_W-1:0] pop_cnt,
	output logic             pop,
	output bk_stat_t         bk_stat,
	rld_out_if.source        levels
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  rem_q;
	logic [MEAN_W-1:0] dvd_q;    // dividend bits, then quotient, then radicand
	logic [CNT_W-1:0]  dsr_q;
	logic [ROOT_W+1:0] sr_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] lvl_q;
	logic              flag_q;
	logic              ovalid_q;

	logic [CNT_W:0]    rem_sh;
	logic              div_ge;
	logic [ROOT_W+3:0] sq_r2;
	logic [ROOT_W+3:0] sq_t;
	logic              sq_ge;
	logic              load;

	logic signed [7:0]  sens_off;
	logic signed [17:0] shift_v;
	logic signed [18:0] thr;
	logic               flag;

	assign pop          = (state_q == ST_IDLE) && !q_stat.empty;
	assign bk_stat.busy = state_q != ST_IDLE;

	assign rem_sh = {rem_q, dvd_q[MEAN_W-1]};
	assign div_ge = rem_sh >= {1'b0, dsr_q};

	assign sq_r2 = {sr_q, dvd_q[MEAN_W-1 -: 2]};
	assign sq_t  = {2'b00, root_q, 2'b01};
	assign sq_ge = sq_r2 >= sq_t;

	// threshold may go negative; a negative threshold never raises the flag
	assign sens_off = $signed({1'b0, cfg.sensitivity}) - $signed(8'(SENS_CENTER));
	assign shift_v  = 18'(sens_off) * $signed(18'(SENS_STEP));
	assign thr      = $signed({3'b000, cfg.noise_base}) + 19'(shift_v);
	assign flag     = !thr[18] && ($signed({11'b0, root_q}) > thr);

	assign load = (state_q == ST_DONE) && (!ovalid_q || levels.ready);

	assign levels.valid           = ovalid_q;
	assign levels.rms_level       = lvl_q;
	assign levels.above_threshold = flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(MEAN_W - 1)) begin
						state_q <= ST_SQRT;
						step_q  <= '0;
					end
				end
				ST_SQRT: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(ROOT_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (load) begin
				ovalid_q <= 1'b1;
			end else if (levels.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// high part of the sum is always below the count
				rem_q <= CNT_W'(pop_sum >> MEAN_W);
				dvd_q <= pop_sum[MEAN_W-1:0];
				dsr_q <= pop_cnt;
			end
			ST_DIV: begin
				rem_q <= CNT_W'(div_ge ? rem_sh - {1'b0, dsr_q} : rem_sh);
				dvd_q <= {dvd_q[MEAN_W-2:0], div_ge};
				sr_q   <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				sr_q   <= sq_ge ? (ROOT_W + 2)'(sq_r2 - sq_t) : (ROOT_W + 2)'(sq_r2);
				root_q <= {root_q[ROOT_W-2:0], sq_ge};
				dvd_q  <= {dvd_q[MEAN_W-3:0], 2'b00};
			end
			ST_DONE: begin
				if (load) begin
					lvl_q  <= root_q;
					flag_q <= flag;
				end
			end
			default: begin
				lvl_q <= lvl_q;
			end
		endcase
	end

endmodule

### hdl/rms_level_detector_unit.sv
// ----------------------------------------------------------------------------
// rms_level_detector_unit
// RMS level of sample windows with a noise threshold flag.
//
//   channel   dir  payload                       beat when
//   samples   in   sample[7:0], last_sample      valid && ready
//   levels    out  rms_level[7:0], above_thr.    valid && ready
//   cfg       in   cfg_index, cfg_wdata[15:0]    cfg_we
//
// One sample per cycle enters the accumulator. Each finished window then
// passes through the arithmetic unit: a start in the idle state, 16 division
// steps, 8 root steps and a compare-and-load in the done state.
// A two-window queue lets sampling run on while a window is worked out;
// samples stall only when both queue slots are taken.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rms_level_detector_unit
	import rld_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	localparam int CNT_W = cnt_width(MAX_WINDOW),
	localparam int SUM_W = sum_width(MAX_WINDOW)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rld_in_if.sink                samples,
	rld_out_if.source             levels,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t             cfg_q;
	q_stat_t          q_stat;
	bk_stat_t         bk_stat;
	logic             push;
	logic [SUM_W-1:0] push_sum;
	logic [CNT_W-1:0] push_cnt;
	logic             pop;
	logic [SUM_W-1:0] pop_sum;
	logic [CNT_W-1:0] pop_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensitivity <= SENS_W'(SENS_RESET);
			cfg_q.noise_base  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SENSITIVITY: cfg_q.sensitivity <= cfg_wdata[SENS_W-1:0];
				REG_NOISE_BASE:  cfg_q.noise_base  <= cfg_wdata[BASE_W-1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	rld_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.q_stat   (q_stat),
		.push     (push),
		.push_sum (push_sum),
		.push_cnt (push_cnt)
	);

	rld_queue #(.MAX_WINDOW(MAX_WINDOW)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_sum (push_sum),
		.push_cnt (push_cnt),
		.pop      (pop),
		.pop_sum  (pop_sum),
		.pop_cnt  (pop_cnt),
		.q_stat   (q_stat)
	);

	rld_back #(.MAX_WINDOW(MAX_WINDOW)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.pop_sum  (pop_sum),
		.pop_cnt  (pop_cnt),
		.pop      (pop),
		.bk_stat  (bk_stat),
		.levels   (levels)
	);

`include "rms_level_detector_unit_macros.svh"

	`RLD_ASSERT_SAME(a_queue_no_overflow, q_stat.full, !push)
	`RLD_ASSERT_NEXT(a_back_picks_up, !bk_stat.busy && !q_stat.empty, bk_stat.busy)
	`RLD_ASSERT_NEXT(a_window_queued, push, !q_stat.empty || bk_stat.busy)

endmodule
